### sv/ble_pkg.sv
package ble_pkg;

  localparam int NODE_SLOTS = 64;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int ID_W       = 16;
  localparam int MAX_OUT    = 3;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam int IDX_W      = $clog2(MAX_OUT);

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_MSG   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [7:0] KIND_ELECTION = 8'd0;
  localparam logic [7:0] KIND_ANSWER   = 8'd1;
  localparam logic [7:0] KIND_COORD    = 8'd2;
  localparam logic [7:0] KIND_ALIVE    = 8'd3;

  localparam logic [1:0] SEND_ELECTION = 2'd0;
  localparam logic [1:0] SEND_ANSWER   = 2'd1;
  localparam logic [1:0] SEND_COORD    = 2'd2;
  localparam logic [1:0] SEND_ALIVE    = 2'd3;

  localparam logic [1:0] ROLE_NORMAL   = 2'd0;
  localparam logic [1:0] ROLE_ELECTING = 2'd1;
  localparam logic [1:0] ROLE_WAITING  = 2'd2;

  localparam logic [1:0] CFG_OWN_ID         = 2'd0;
  localparam logic [1:0] CFG_ELECTION_WAIT  = 2'd1;
  localparam logic [1:0] CFG_LEADER_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_HEARTBEAT      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] own_id;
    logic [15:0]     election_wait;
    logic [15:0]     leader_timeout;
    logic [15:0]     heartbeat;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    logic [MAX_OUT-1:0][1:0]      kind;
    logic [MAX_OUT-1:0][ID_W-1:0] target;
    logic [MAX_OUT-1:0][15:0]     seq;
    logic [ID_W-1:0]              leader;
    logic [1:0]                   role;
  } bundle_t;

  function automatic logic [15:0] period(input logic [15:0] p);
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

endpackage

### sv/ble_in_if.sv
interface ble_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  msg_kind;
  logic [15:0] sender;
  logic [15:0] target;
  logic [15:0] msg_seq;
  logic        length_ok;

  modport source (
    output valid, command, msg_kind, sender, target, msg_seq, length_ok,
    input  ready
  );
  modport sink (
    input  valid, command, msg_kind, sender, target, msg_seq, length_ok,
    output ready
  );
endinterface

### sv/ble_out_if.sv
interface ble_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  send_kind;
  logic [15:0] send_target;
  logic [15:0] send_seq;
  logic [15:0] leader_now;
  logic [1:0]  role_now;
  logic        last;

  modport source (
    output valid, send_kind, send_target, send_seq, leader_now, role_now, last,
    input  ready
  );
  modport sink (
    input  valid, send_kind, send_target, send_seq, leader_now, role_now, last,
    output ready
  );
endinterface

### sv/bully_leader_election_node_top.sv
// channel   dir  payload                                                   beat when
// in_bus    in   command, msg_kind, sender, target, msg_seq, length_ok     valid & ready
// out_bus   out  send_kind, send_target, send_seq, leader_now, role_now,   valid & ready
//                last
// cfg_*     in   cfg_idx selects register, cfg_wdata                       cfg_we
//
// an item is accepted into stage one as its seen-sequence table read is issued
// state is written back when stage one moves on, which a busy output can hold off
// a new item can be taken every cycle unless stage one is stalled; an item with k
// results holds the output register for k beats, and the next item with results waits
// synchronous reset clears role, leader, round, timers and table valid bits
// out_bus stalls hold the bundle; an item with results waits and in_bus ready drops
module bully_leader_election_node_top (
  input  logic        clk,
  input  logic        rst_n,
  ble_in_if.sink      in_bus,
  ble_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import ble_pkg::*;

  cfg_t    cfg_r;
  logic    ob_free;
  logic    ob_load;
  bundle_t ob_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id         <= 16'd1;
      cfg_r.election_wait  <= 16'd50;
      cfg_r.leader_timeout <= 16'd200;
      cfg_r.heartbeat      <= 16'd80;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OWN_ID:         cfg_r.own_id         <= cfg_wdata;
        CFG_ELECTION_WAIT:  cfg_r.election_wait  <= cfg_wdata;
        CFG_LEADER_TIMEOUT: cfg_r.leader_timeout <= cfg_wdata;
        CFG_HEARTBEAT:      cfg_r.heartbeat      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ble_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_bus  (in_bus),
    .ob_free (ob_free),
    .ob_load (ob_load),
    .ob_data (ob_data)
  );

  ble_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ob_load (ob_load),
    .ob_data (ob_data),
    .ob_free (ob_free),
    .out_bus (out_bus)
  );

endmodule

### sv/ble_ram.sv
module ble_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ble_core.sv
module ble_core (
  input  logic            clk,
  input  logic            rst_n,
  input  ble_pkg::cfg_t   cfg,
  ble_in_if.sink          in_bus,
  input  logic            ob_free,
  output logic            ob_load,
  output ble_pkg::bundle_t ob_data
);
  import ble_pkg::*;

  // stage one: registered item waiting for table read data
  logic              s1_valid_r;
  logic [1:0]        s1_cmd_r;
  logic [7:0]        s1_kind_r;
  logic [ID_W-1:0]   s1_from_r;
  logic [ID_W-1:0]   s1_to_r;
  logic [15:0]       s1_seq_r;
  logic              s1_len_r;
  logic              s1_slot_r;
  logic [SLOT_W-1:0] s1_addr_r;
  logic              fwd_hit_r;
  logic [15:0]       fwd_data_r;

  logic [1:0]      role_r;
  logic [ID_W-1:0] leader_r;
  logic [15:0]     round_r;
  logic            answered_r;
  logic [15:0]     ecount_r;
  logic [15:0]     lcount_r;
  logic [15:0]     hcount_r;
  logic [NODE_SLOTS-1:0] seen_vld_r;

  logic [1:0]      role_nxt;
  logic [ID_W-1:0] leader_nxt;
  logic [15:0]     round_nxt;
  logic            answered_nxt;
  logic [15:0]     ecount_nxt;
  logic [15:0]     lcount_nxt;
  logic [15:0]     hcount_nxt;

  logic              in_fire;
  logic              in_slot;
  logic [SLOT_W-1:0] in_addr;
  logic [15:0]       ram_rdata;
  logic [15:0]       entry;
  logic              tbl_we;
  logic              tbl_wr;
  logic              s1_go;
  logic [CNT_W-1:0]  n;
  logic              filt;
  logic              dup;
  bundle_t           bnd;

  assign in_slot = (in_bus.sender != '0) && (in_bus.sender <= ID_W'(NODE_SLOTS));
  assign in_addr = SLOT_W'(in_bus.sender - 16'd1);
  assign in_fire = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !s1_valid_r || s1_go;

  assign entry = fwd_hit_r ? fwd_data_r :
                 (seen_vld_r[s1_addr_r] ? ram_rdata : 16'd0);

  always_comb begin
    role_nxt     = role_r;
    leader_nxt   = leader_r;
    round_nxt    = round_r;
    answered_nxt = answered_r;
    ecount_nxt   = ecount_r;
    lcount_nxt   = lcount_r;
    hcount_nxt   = hcount_r;
    tbl_we       = 1'b0;
    filt         = 1'b0;
    dup          = 1'b0;
    n            = '0;
    bnd          = '0;

    case (s1_cmd_r)
      CMD_TICK: begin
        if (ecount_nxt != 16'd0) begin
          ecount_nxt = ecount_nxt - 16'd1;
          if (ecount_nxt == 16'd0 && !answered_nxt &&
              (role_nxt == ROLE_ELECTING || role_nxt == ROLE_WAITING)) begin
            leader_nxt = cfg.own_id;
            role_nxt   = ROLE_NORMAL;
            if (n != CNT_W'(MAX_OUT)) begin
              bnd.kind[IDX_W'(n)]   = SEND_COORD;
              bnd.target[IDX_W'(n)] = '0;
              bnd.seq[IDX_W'(n)]    = round_nxt;
              n = n + 1'b1;
            end
            hcount_nxt = period(cfg.heartbeat);
          end
        end
        if (lcount_nxt != 16'd0) begin
          lcount_nxt = lcount_nxt - 16'd1;
          if (lcount_nxt == 16'd0) begin
            if (role_nxt == ROLE_WAITING || leader_nxt == '0 ||
                leader_nxt != cfg.own_id) begin
              leader_nxt = (role_nxt == ROLE_WAITING || leader_nxt == '0) ?
                           leader_nxt : '0;
              if (role_nxt != ROLE_ELECTING) begin
                role_nxt     = ROLE_ELECTING;
                round_nxt    = round_nxt + 16'd1;
                answered_nxt = 1'b0;
                if (n != CNT_W'(MAX_OUT)) begin
                  bnd.kind[IDX_W'(n)]   = SEND_ELECTION;
                  bnd.target[IDX_W'(n)] = '0;
                  bnd.seq[IDX_W'(n)]    = round_nxt;
                  n = n + 1'b1;
                end
              end
              ecount_nxt = period(cfg.election_wait);
            end
            lcount_nxt = period(cfg.leader_timeout);
          end
        end
        if (hcount_nxt != 16'd0) begin
          hcount_nxt = hcount_nxt - 16'd1;
          if (hcount_nxt == 16'd0) begin
            if (leader_nxt == cfg.own_id && n != CNT_W'(MAX_OUT)) begin
              bnd.kind[IDX_W'(n)]   = SEND_ALIVE;
              bnd.target[IDX_W'(n)] = '0;
              bnd.seq[IDX_W'(n)]    = round_nxt;
              n = n + 1'b1;
            end
            hcount_nxt = period(cfg.heartbeat);
          end
        end
      end
      CMD_MSG: begin
        if (s1_len_r && s1_from_r != cfg.own_id) begin
          filt = !(s1_kind_r == KIND_ANSWER || s1_kind_r == KIND_COORD ||
                   s1_kind_r == KIND_ALIVE);
          if (filt && s1_slot_r) begin
            if (entry >= s1_seq_r) begin
              dup = 1'b1;
            end else begin
              tbl_we = 1'b1;
            end
          end
          if (!dup) begin
            case (s1_kind_r)
              KIND_ELECTION: begin
                if ((s1_to_r == '0 || s1_to_r == cfg.own_id) &&
                    cfg.own_id > s1_from_r) begin
                  bnd.kind[IDX_W'(n)]   = SEND_ANSWER;
                  bnd.target[IDX_W'(n)] = s1_from_r;
                  bnd.seq[IDX_W'(n)]    = s1_seq_r;
                  n = n + 1'b1;
                  if (leader_nxt == cfg.own_id) begin
                    bnd.kind[IDX_W'(n)]   = SEND_COORD;
                    bnd.target[IDX_W'(n)] = '0;
                    bnd.seq[IDX_W'(n)]    = round_nxt;
                    n = n + 1'b1;
                  end
                end
              end
              KIND_ANSWER: begin
                if (s1_to_r == cfg.own_id && role_nxt == ROLE_ELECTING) begin
                  answered_nxt = 1'b1;
                  role_nxt     = ROLE_WAITING;
                  lcount_nxt   = period(cfg.leader_timeout);
                end
              end
              KIND_COORD: begin
                if (s1_from_r >= cfg.own_id) begin
                  leader_nxt = s1_from_r;
                  role_nxt   = ROLE_NORMAL;
                  lcount_nxt = period(cfg.leader_timeout);
                end else if (role_nxt != ROLE_ELECTING) begin
                  role_nxt     = ROLE_ELECTING;
                  round_nxt    = round_nxt + 16'd1;
                  answered_nxt = 1'b0;
                  bnd.kind[IDX_W'(n)]   = SEND_ELECTION;
                  bnd.target[IDX_W'(n)] = '0;
                  bnd.seq[IDX_W'(n)]    = round_nxt;
                  n = n + 1'b1;
                  ecount_nxt = period(cfg.election_wait);
                end
              end
              KIND_ALIVE: begin
                if (s1_from_r > cfg.own_id &&
                    (leader_nxt == '0 || role_nxt == ROLE_WAITING ||
                     s1_from_r > leader_nxt)) begin
                  leader_nxt = s1_from_r;
                  role_nxt   = ROLE_NORMAL;
                  lcount_nxt = period(cfg.leader_timeout);
                end else if (s1_from_r == leader_nxt) begin
                  lcount_nxt = period(cfg.leader_timeout);
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      CMD_START: begin
        if (role_nxt != ROLE_ELECTING) begin
          role_nxt     = ROLE_ELECTING;
          round_nxt    = round_nxt + 16'd1;
          answered_nxt = 1'b0;
          bnd.kind[IDX_W'(n)]   = SEND_ELECTION;
          bnd.target[IDX_W'(n)] = '0;
          bnd.seq[IDX_W'(n)]    = round_nxt;
          n = n + 1'b1;
        end
        ecount_nxt = period(cfg.election_wait);
        lcount_nxt = period(cfg.leader_timeout);
        hcount_nxt = period(cfg.heartbeat);
      end
      default: begin
      end
    endcase

    bnd.cnt    = n;
    bnd.leader = leader_nxt;
    bnd.role   = role_nxt;
  end

  assign s1_go   = s1_valid_r && (n == '0 || ob_free);
  assign ob_load = s1_go && (n != '0);
  assign ob_data = bnd;
  assign tbl_wr  = s1_go && tbl_we;

  ble_ram #(
    .WIDTH (16),
    .DEPTH (NODE_SLOTS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (tbl_wr),
    .waddr (s1_addr_r),
    .wdata (s1_seq_r),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      role_r     <= ROLE_NORMAL;
      leader_r   <= '0;
      round_r    <= '0;
      answered_r <= 1'b0;
      ecount_r   <= '0;
      lcount_r   <= '0;
      hcount_r   <= '0;
      seen_vld_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= tbl_wr && (s1_addr_r == in_addr);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
        fwd_hit_r  <= 1'b0;
      end
      if (s1_go) begin
        role_r     <= role_nxt;
        leader_r   <= leader_nxt;
        round_r    <= round_nxt;
        answered_r <= answered_nxt;
        ecount_r   <= ecount_nxt;
        lcount_r   <= lcount_nxt;
        hcount_r   <= hcount_nxt;
      end
      if (tbl_wr) begin
        seen_vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_bus.command;
      s1_kind_r  <= in_bus.msg_kind;
      s1_from_r  <= in_bus.sender;
      s1_to_r    <= in_bus.target;
      s1_seq_r   <= in_bus.msg_seq;
      s1_len_r   <= in_bus.length_ok;
      s1_slot_r  <= in_slot;
      s1_addr_r  <= in_addr;
      fwd_data_r <= s1_seq_r;
    end
  end

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_valid_r)
    else $error("forward flag set with no item in stage one");

  a_accept_moves_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_valid_r) |-> s1_go)
    else $error("item accepted over a stalled stage one");

  a_write_only_slot: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr |-> (s1_slot_r && s1_cmd_r == CMD_MSG))
    else $error("table written for an item with no slot");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && tbl_wr && s1_addr_r == in_addr) |=> fwd_hit_r)
    else $error("write to the entry being read not forwarded");

endmodule

### sv/ble_outq.sv
module ble_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ob_load,
  input  ble_pkg::bundle_t ob_data,
  output logic             ob_free,
  ble_out_if.source        out_bus
);
  import ble_pkg::*;

  logic             ob_valid_r;
  bundle_t          ob_r;
  logic [CNT_W-1:0] idx_r;
  logic             is_last;
  logic             out_fire;

  assign is_last  = (idx_r == ob_r.cnt - 1'b1);
  assign out_fire = out_bus.valid && out_bus.ready;
  assign ob_free  = !ob_valid_r || (out_fire && is_last);

  assign out_bus.valid       = ob_valid_r;
  assign out_bus.send_kind   = ob_r.kind[IDX_W'(idx_r)];
  assign out_bus.send_target = ob_r.target[IDX_W'(idx_r)];
  assign out_bus.send_seq    = ob_r.seq[IDX_W'(idx_r)];
  assign out_bus.leader_now  = ob_r.leader;
  assign out_bus.role_now    = ob_r.role;
  assign out_bus.last        = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (ob_load) begin
        ob_valid_r <= 1'b1;
        idx_r      <= '0;
      end else if (out_fire) begin
        if (is_last) begin
          ob_valid_r <= 1'b0;
          idx_r      <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_load) begin
      ob_r <= ob_data;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ob_valid_r |-> (idx_r < ob_r.cnt))
    else $error("beat index beyond bundle count");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ob_load |-> ob_free)
    else $error("bundle loaded over one still in flight");

  a_not_last_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !is_last) |=> (ob_valid_r && idx_r == $past(idx_r) + 1'b1))
    else $error("bundle dropped before its final beat");

endmodule
